>>> sv/kst_pkg.sv
`default_nettype none

package kst_pkg;

   // Field widths
   localparam int CHAR_W  = 8;
   localparam int KIND_W  = 5;
   localparam int VALUE_W = 31;
   localparam int LINE_W  = 16;
   localparam int COL_W   = 12;
   localparam int LEN_W   = 12;

   // Sizing
   localparam longint MAX_LINE_LEN  = 4096;
   localparam longint MAX_LINES     = 65535;
   localparam int     KEYWORD_CHARS = 6;
   localparam int     WINDOW_BITS   = 48;
   localparam int     KW_COUNT      = 9;
   localparam int     RSP_DEPTH     = 4;

   localparam logic [COL_W-1:0] COL_LAST =
      COL_W'((MAX_LINE_LEN - 1 < 4095) ? MAX_LINE_LEN - 1 : 4095);
   localparam logic [LINE_W-1:0] LINE_LAST =
      LINE_W'((MAX_LINES < 65535) ? MAX_LINES : 65535);
   localparam logic [LEN_W-1:0]   LEN_MAX = '1;
   localparam logic [VALUE_W-1:0] NUM_MAX = '1;

   // Token kinds (keywords take their table index, 0 to 8)
   localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd9;
   localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd10;
   localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd11;
   localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd12;
   localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd13;
   localparam logic [KIND_W-1:0] KIND_DOT    = 5'd14;
   localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd15;
   localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd16;
   localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd17;
   localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd18;
   localparam logic [KIND_W-1:0] KIND_STAR   = 5'd19;
   localparam logic [KIND_W-1:0] KIND_BANG   = 5'd20;
   localparam logic [KIND_W-1:0] KIND_NE     = 5'd21;
   localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd22;
   localparam logic [KIND_W-1:0] KIND_EQ     = 5'd23;
   localparam logic [KIND_W-1:0] KIND_GT     = 5'd24;
   localparam logic [KIND_W-1:0] KIND_GE     = 5'd25;
   localparam logic [KIND_W-1:0] KIND_LT     = 5'd26;
   localparam logic [KIND_W-1:0] KIND_LE     = 5'd27;
   localparam logic [KIND_W-1:0] KIND_AND    = 5'd28;
   localparam logic [KIND_W-1:0] KIND_OR     = 5'd29;
   localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd30;
   localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd31;

   // Packed keyword text, last byte in the low bits
   localparam logic [WINDOW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
      48'h0000_656C_7365,   // else
      48'h0066_616C_7365,   // false
      48'h0000_0066_6F72,   // for
      48'h0000_0000_6966,   // if
      48'h7265_7475_726E,   // return
      48'h0000_7472_7565,   // true
      48'h0077_6869_6C65,   // while
      48'h0000_0069_6E74,   // int
      48'h0000_6368_6172    // char
   };
   localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      12'd4, 12'd5, 12'd3, 12'd2, 12'd6, 12'd4, 12'd5, 12'd3, 12'd4
   };

   typedef struct packed {
      logic [KIND_W-1:0]  token_kind;
      logic               status;
      logic [VALUE_W-1:0] number_value;
      logic [LINE_W-1:0]  line_number;
      logic [COL_W-1:0]   start_column;
      logic [LEN_W-1:0]   token_length;
      logic               last_of_run;
   } kst_result_type;

   typedef struct packed {
      logic [1:0]     count;
      kst_result_type first;
      kst_result_type second;
   } kst_push_type;

   function automatic logic [KIND_W-1:0] word_kind(
      input logic [WINDOW_BITS-1:0] window,
      input logic [LEN_W-1:0]       size
   );
      logic [KIND_W-1:0] kind;
      kind = KIND_IDENT;
      if (size <= LEN_W'(KEYWORD_CHARS) && size <= LEN_W'(8)) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if (KW_LEN[k] == size && KW_TEXT[k] == window) begin
               kind = KIND_W'(k);
            end
         end
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

>>> sv/kst_if.sv
`default_nettype none

interface kst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface kst_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic        status;
   logic [30:0] number_value;
   logic [15:0] line_number;
   logic [11:0] start_column;
   logic [11:0] token_length;
   logic        last_of_run;

   modport source (
      output valid, output token_kind, output status, output number_value,
      output line_number, output start_column, output token_length,
      output last_of_run, input ready
   );
   modport sink (
      input valid, input token_kind, input status, input number_value,
      input line_number, input start_column, input token_length,
      input last_of_run, output ready
   );
endinterface

`default_nettype wire

>>> sv/kst_scan.sv
`default_nettype none

module kst_scan
   import kst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [CHAR_W-1:0] char_code,
   output kst_push_type      push
);

   localparam logic [2:0] PEND_NONE = 3'd0;
   localparam logic [2:0] PEND_BANG = 3'd1;
   localparam logic [2:0] PEND_EQ   = 3'd2;
   localparam logic [2:0] PEND_GT   = 3'd3;
   localparam logic [2:0] PEND_LT   = 3'd4;
   localparam logic [2:0] PEND_AMP  = 3'd5;
   localparam logic [2:0] PEND_BAR  = 3'd6;

   typedef struct packed {
      logic [COL_W-1:0]       begin_col;
      logic [LEN_W-1:0]       size;
      logic [WINDOW_BITS-1:0] window;
      logic                   digit_led;
      logic                   digits_closed;
      logic [VALUE_W-1:0]     acc;
      logic                   overflow;
   } kst_word_type;

   function automatic logic [2:0] pend_code(input logic [CHAR_W-1:0] c);
      case (c)
         "!":     return PEND_BANG;
         "=":     return PEND_EQ;
         ">":     return PEND_GT;
         "<":     return PEND_LT;
         "&":     return PEND_AMP;
         "|":     return PEND_BAR;
         default: return PEND_NONE;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] pair_second(input logic [2:0] p);
      case (p)
         PEND_AMP: return "&";
         PEND_BAR: return "|";
         default:  return "=";
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] pend_char(input logic [2:0] p);
      case (p)
         PEND_AMP: return "&";
         default:  return "|";
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] single_of(input logic [2:0] p);
      case (p)
         PEND_EQ: return KIND_ASSIGN;
         PEND_GT: return KIND_GT;
         PEND_LT: return KIND_LT;
         default: return KIND_BANG;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] pair_of(input logic [2:0] p);
      case (p)
         PEND_EQ:  return KIND_EQ;
         PEND_GT:  return KIND_GE;
         PEND_LT:  return KIND_LE;
         PEND_AMP: return KIND_AND;
         PEND_BAR: return KIND_OR;
         default:  return KIND_NE;
      endcase
   endfunction

   // {hit, kind} for the one-byte symbols that never wait
   function automatic logic [KIND_W:0] single_sym(input logic [CHAR_W-1:0] c);
      case (c)
         "(":     return {1'b1, KIND_LPAREN};
         ")":     return {1'b1, KIND_RPAREN};
         "{":     return {1'b1, KIND_LBRACE};
         "}":     return {1'b1, KIND_RBRACE};
         ",":     return {1'b1, KIND_COMMA};
         ".":     return {1'b1, KIND_DOT};
         "-":     return {1'b1, KIND_MINUS};
         "+":     return {1'b1, KIND_PLUS};
         ";":     return {1'b1, KIND_SEMI};
         "/":     return {1'b1, KIND_SLASH};
         "*":     return {1'b1, KIND_STAR};
         default: return {1'b0, KIND_IDENT};
      endcase
   endfunction

   // Append a lone & or |, never a digit
   function automatic kst_word_type add_mark(
      input kst_word_type      w,
      input logic [CHAR_W-1:0] c,
      input logic [COL_W-1:0]  col
   );
      kst_word_type r;
      r = w;
      if (w.size == '0) begin
         r.begin_col = col;
         r.digit_led = 1'b0;
         r.acc       = '0;
         r.overflow  = 1'b0;
         r.window    = '0;
      end
      r.window        = {r.window[WINDOW_BITS-CHAR_W-1:0], c};
      r.digits_closed = 1'b1;
      if (r.size != LEN_MAX) begin
         r.size = r.size + LEN_W'(1);
      end
      return r;
   endfunction

   function automatic kst_word_type add_byte(
      input kst_word_type      w,
      input logic [CHAR_W-1:0] c,
      input logic [COL_W-1:0]  col
   );
      kst_word_type r;
      logic         dig;
      logic [34:0]  v;
      r   = w;
      dig = (c >= "0") && (c <= "9");
      v   = '0;
      if (w.size == '0) begin
         r.begin_col     = col;
         r.digit_led     = dig;
         r.digits_closed = !dig;
         r.acc           = '0;
         r.overflow      = 1'b0;
         r.window        = '0;
      end
      r.window = {r.window[WINDOW_BITS-CHAR_W-1:0], c};
      if (r.size != LEN_MAX) begin
         r.size = r.size + LEN_W'(1);
      end
      if (!r.digits_closed) begin
         if (dig) begin
            // acc * 10 + digit as two shifted adds
            v = 35'({r.acc, 3'b000}) + 35'({r.acc, 1'b0}) + 35'(c[3:0]);
            if (v > 35'(NUM_MAX)) begin
               r.overflow      = 1'b1;
               r.digits_closed = 1'b1;
            end else begin
               r.acc = v[VALUE_W-1:0];
            end
         end else begin
            r.digits_closed = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic kst_result_type make_result(
      input logic [KIND_W-1:0] kind,
      input logic [COL_W-1:0]  col,
      input logic [LEN_W-1:0]  len,
      input logic [LINE_W-1:0] line
   );
      kst_result_type r;
      r.token_kind   = kind;
      r.status       = 1'b0;
      r.number_value = '0;
      r.line_number  = line;
      r.start_column = col;
      r.token_length = len;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   function automatic kst_result_type word_result(
      input kst_word_type      w,
      input logic [LINE_W-1:0] line
   );
      kst_result_type r;
      r = make_result(word_kind(w.window, w.size), w.begin_col, w.size, line);
      if (w.digit_led) begin
         r.token_kind   = KIND_NUMBER;
         r.status       = w.overflow;
         r.number_value = w.overflow ? '0 : w.acc;
      end
      return r;
   endfunction

   logic [LINE_W-1:0] line_ff, line_in;
   logic [COL_W-1:0]  column_ff, column_in;
   kst_word_type      word_ff, word_in;
   logic [2:0]        pend_ff, pend_in;
   logic [COL_W-1:0]  pend_col_ff, pend_col_in;
   logic              halted_ff, halted_in;

   logic              match;
   logic              a_fire, w_fire, b_fire, closes, halt_now;
   logic [2:0]        code;
   logic [KIND_W:0]   sym;
   logic              blank;
   kst_word_type      w1, wc;
   kst_result_type    res_a, res_w, res_b;
   kst_result_type    first, second;
   logic [1:0]        n;

   always_comb begin
      match  = (pend_ff != PEND_NONE) && (char_code == pair_second(pend_ff));
      a_fire = !match && (pend_ff != PEND_NONE) && (pend_ff <= PEND_LT);
      w1     = (!match && (pend_ff == PEND_AMP || pend_ff == PEND_BAR))
               ? add_mark(word_ff, pend_char(pend_ff), pend_col_ff) : word_ff;
      code   = pend_code(char_code);
      sym    = single_sym(char_code);
      blank  = (char_code == " ") || (char_code == "\t") || (char_code == "\n");
      closes = match || (code != PEND_NONE && code <= PEND_LT) || blank || sym[KIND_W];
      wc     = match ? word_ff : w1;
      w_fire   = closes && (wc.size != '0);
      halt_now = w_fire && wc.digit_led && wc.overflow;
      b_fire   = (match || sym[KIND_W]) && !halt_now;

      res_a = make_result(single_of(pend_ff), pend_col_ff, LEN_W'(1), line_ff);
      res_w = word_result(wc, line_ff);
      res_b = match ? make_result(pair_of(pend_ff), pend_col_ff, LEN_W'(2), line_ff)
                    : make_result(sym[KIND_W-1:0], column_ff, LEN_W'(1), line_ff);

      // Order is: waiting single symbol, closed word, then pair or new symbol
      first  = res_b;
      second = res_b;
      n      = 2'd0;
      if (a_fire) begin
         first = res_a;
         if (w_fire) begin
            second = res_w;
            n      = 2'd2;
         end else if (b_fire) begin
            n = 2'd2;
         end else begin
            n = 2'd1;
         end
      end else if (w_fire) begin
         first = res_w;
         n     = b_fire ? 2'd2 : 2'd1;
      end else if (b_fire) begin
         n = 2'd1;
      end
      if (!take || halted_ff) begin
         n = 2'd0;
      end
      first.last_of_run  = (n == 2'd1);
      second.last_of_run = (n == 2'd2);
      push.count  = n;
      push.first  = first;
      push.second = second;

      // Next state
      line_in     = line_ff;
      column_in   = column_ff;
      word_in     = word_ff;
      pend_in     = pend_ff;
      pend_col_in = pend_col_ff;
      halted_in   = halted_ff;
      if (take && !halted_ff) begin
         if (closes) begin
            word_in      = wc;
            word_in.size = '0;
         end else if (code != PEND_NONE) begin
            word_in = w1;
         end else begin
            word_in = add_byte(w1, char_code, column_ff);
         end
         pend_in     = match ? PEND_NONE : code;
         pend_col_in = column_ff;
         halted_in   = halt_now;
         if (char_code == "\n") begin
            if (line_ff != LINE_LAST) begin
               line_in = line_ff + LINE_W'(1);
            end
            column_in = '0;
         end else if (column_ff != COL_LAST) begin
            column_in = column_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff     <= LINE_W'(1);
         column_ff   <= '0;
         word_ff     <= '0;
         pend_ff     <= PEND_NONE;
         pend_col_ff <= '0;
         halted_ff   <= 1'b0;
      end else begin
         line_ff     <= line_in;
         column_ff   <= column_in;
         word_ff     <= word_in;
         pend_ff     <= pend_in;
         pend_col_ff <= pend_col_in;
         halted_ff   <= halted_in;
      end
   end

`ifndef ASSERT_OFF
   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt released without reset");
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> push.count == 2'd0)
      else $error("result produced while halted");
   a_push_limit: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("more than two results for one byte");
`endif

endmodule

`default_nettype wire

>>> sv/kst_rsp_fifo.sv
`default_nettype none

module kst_rsp_fifo
   import kst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  kst_push_type push,
   output logic         room,
   kst_rsp_if.source    rsp
);

   // RSP_DEPTH is a power of two so the pointers wrap by themselves
   localparam int PTR_W   = $clog2(RSP_DEPTH);
   localparam int COUNT_W = $clog2(RSP_DEPTH + 1);

   kst_result_type     slot_ff [RSP_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               pop;
   kst_result_type     head;

   assign head = slot_ff[rd_ptr_ff];
   assign pop  = rsp.valid && rsp.ready;
   assign room = count_ff <= COUNT_W'(RSP_DEPTH - 2);

   assign rsp.valid        = count_ff != '0;
   assign rsp.token_kind   = head.token_kind;
   assign rsp.status       = head.status;
   assign rsp.number_value = head.number_value;
   assign rsp.line_number  = head.line_number;
   assign rsp.start_column = head.start_column;
   assign rsp.token_length = head.token_length;
   assign rsp.last_of_run  = head.last_of_run;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + COUNT_W'(push.count) - COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(RSP_DEPTH))
      else $error("result queue overrun");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("results pushed without room for two");
`endif

endmodule

`default_nettype wire

>>> sv/keyword_and_symbol_tokenizer.sv
`default_nettype none
// Flow: a transferred byte waits in the input register until the result queue
//   has room for two results; its results are then registered into the queue and offered on rsp.
// Throughput: one byte per cycle while the result queue has room for two results;
//   the queue gives out one result per transfer, so bytes with two results slow the input.
// Reset (synchronous): line 1, column 0, no open word, nothing waiting, not
//   halted, result queue empty; no clearing pass.

module keyword_and_symbol_tokenizer
   import kst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   kst_req_if.sink   req,
   kst_rsp_if.source rsp
);

   // Input register: holds one byte until the scanner can take it
   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              room;
   logic              take;
   kst_push_type      push;

   // Advance only with room for two results, the most one byte can make
   assign take      = in_valid_ff && room;
   assign req.ready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.ready) begin
         in_valid_in = req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Byte register carries payload only: load on each transfer
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_char_ff <= req.char_code;
      end
   end

   // Scanner: line/column counters, open word, waiting symbol, halt flag
   kst_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_code (in_char_ff),
      .push      (push)
   );

   // Result queue: takes up to two results per cycle, gives one per transfer
   kst_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

>>> test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kst_pkg::*;

   // Run shape
   localparam int          RANDOM_CHARS = 980;
   localparam int          IDLE_PERCENT = 38;
   localparam int          HOLD_AFTER   = 300;   // transfers in before the long hold-off
   localparam int          HOLD_CYCLES  = 250;
   localparam int          STEADY_FROM  = 600;   // stretch with no idling on either side
   localparam int          STEADY_TO    = 800;
   localparam int          DRAIN_LIMIT  = 4000;
   localparam int          DRAIN_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT  = 40_000;

   // Bytes with a role of their own
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Largest leading-digit value that still makes a good number
   localparam logic [34:0] VALUE_CEILING = 35'h7FFF_FFFF;

   // A byte that may start a two-byte symbol waits here for the next one
   typedef enum logic [2:0] {
      HELD_NONE, HELD_BANG, HELD_EQ, HELD_GT, HELD_LT, HELD_AMP, HELD_BAR
   } held_symbol_type;

   logic clock = 1'b0;
   logic reset;

   kst_req_if req_chan ();
   kst_rsp_if rsp_chan ();

   keyword_and_symbol_tokenizer u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   string keyword_words [KW_COUNT] = '{
      "else", "false", "for", "if", "return", "true", "while", "int", "char"
   };
   string symbol_words [23] = '{
      "(", ")", "{", "}", ",", ".", "-", "+", ";", "/", "*", "!", "!=", "=", "==",
      ">", ">=", "<", "<=", "&&", "||", "&", "|"
   };

   logic [7:0]     char_backlog [$];
   kst_result_type expected_tokens [$];
   kst_result_type step_tokens [$];

   int          chars_taken = 0;
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   logic        steady;

   assign steady = (chars_taken >= STEADY_FROM) && (chars_taken < STEADY_TO);

   // ---------------------------------------------------------------------------
   // Token predictor state, starting from the reset values
   // ---------------------------------------------------------------------------
   logic [LINE_W-1:0]      at_line         = 16'd1;
   logic [COL_W-1:0]       at_column       = '0;
   logic [COL_W-1:0]       word_start      = '0;
   logic [LEN_W-1:0]       word_len        = '0;   // zero: no word open
   logic [WINDOW_BITS-1:0] word_tail       = '0;   // last six bytes of the word
   logic                   word_numeric    = 1'b0;
   logic                   digits_done     = 1'b0;
   logic [VALUE_W-1:0]     word_value      = '0;
   logic                   value_overflow  = 1'b0;
   held_symbol_type        held_symbol     = HELD_NONE;
   logic [COL_W-1:0]       held_column     = '0;
   logic                   tokenizer_halted = 1'b0;

   // Queue one token of this byte; at most two, and nothing once halted
   task automatic add_token(input logic [KIND_W-1:0] kind, input logic status,
                            input logic [VALUE_W-1:0] value, input logic [COL_W-1:0] col,
                            input logic [LEN_W-1:0] len);
      kst_result_type t;
      if (tokenizer_halted || step_tokens.size() >= 2) return;
      t.token_kind   = kind;
      t.status       = status;
      t.number_value = value;
      t.line_number  = at_line;
      t.start_column = col;
      t.token_length = len;
      t.last_of_run  = 1'b0;
      step_tokens = {step_tokens, t};
   endtask

   function automatic logic [KIND_W-1:0] classify_word();
      logic [WINDOW_BITS-1:0] kw_image;
      logic [KIND_W-1:0]      kind;
      kind = KIND_IDENT;
      if (word_len <= LEN_W'(KEYWORD_CHARS)) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            kw_image = '0;
            for (int n = 0; n < keyword_words[k].len(); n++)
               kw_image = {kw_image[WINDOW_BITS-9:0], keyword_words[k][n]};
            if (keyword_words[k].len() == word_len && kw_image == word_tail)
               kind = KIND_W'(k);
         end
      end
      return kind;
   endfunction

   // Give out the open word, if any. An oversized number halts the tokenizer.
   task automatic close_word();
      if (word_len == 0) return;
      if (word_numeric && value_overflow) begin
         add_token(KIND_NUMBER, 1'b1, '0, word_start, word_len);
         tokenizer_halted = 1'b1;
      end else if (word_numeric) begin
         add_token(KIND_NUMBER, 1'b0, word_value, word_start, word_len);
      end else begin
         add_token(classify_word(), 1'b0, '0, word_start, word_len);
      end
      word_len = '0;
   endtask

   task automatic add_char(input logic [7:0] c, input logic [COL_W-1:0] col);
      logic        dig;
      logic [34:0] grown;
      dig = (c >= "0") && (c <= "9");
      if (word_len == 0) begin
         word_start     = col;
         word_numeric   = dig;
         digits_done    = !dig;
         word_value     = '0;
         value_overflow = 1'b0;
         word_tail      = '0;
      end
      word_tail = {word_tail[WINDOW_BITS-9:0], c};
      if (word_len != LEN_MAX) word_len = word_len + 1'b1;
      if (!digits_done && !dig) begin
         digits_done = 1'b1;
      end else if (!digits_done) begin
         grown = 35'(word_value) * 35'd10 + 35'(c - "0");
         if (grown > VALUE_CEILING) begin
            value_overflow = 1'b1;
            digits_done    = 1'b1;
         end else begin
            word_value = grown[VALUE_W-1:0];
         end
      end
   endtask

   function automatic held_symbol_type held_of(input logic [7:0] c);
      case (c)
         "!":     return HELD_BANG;
         "=":     return HELD_EQ;
         ">":     return HELD_GT;
         "<":     return HELD_LT;
         "&":     return HELD_AMP;
         "|":     return HELD_BAR;
         default: return HELD_NONE;
      endcase
   endfunction

   function automatic logic single_symbol(input logic [7:0] c,
                                          output logic [KIND_W-1:0] kind);
      single_symbol = 1'b1;
      kind = KIND_IDENT;
      case (c)
         "(":     kind = KIND_LPAREN;
         ")":     kind = KIND_RPAREN;
         "{":     kind = KIND_LBRACE;
         "}":     kind = KIND_RBRACE;
         ",":     kind = KIND_COMMA;
         ".":     kind = KIND_DOT;
         "-":     kind = KIND_MINUS;
         "+":     kind = KIND_PLUS;
         ";":     kind = KIND_SEMI;
         "/":     kind = KIND_SLASH;
         "*":     kind = KIND_STAR;
         default: single_symbol = 1'b0;
      endcase
   endfunction

   // A byte that no waiting symbol swallowed
   task automatic take_char(input logic [7:0] c, input logic [COL_W-1:0] col);
      held_symbol_type   h;
      logic [KIND_W-1:0] kind;
      h = held_of(c);
      if (h != HELD_NONE) begin
         // only the comparison starters cut the word; & and | may still join it
         if (h != HELD_AMP && h != HELD_BAR) close_word();
         held_symbol = h;
         held_column = col;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
         close_word();
      end else if (single_symbol(c, kind)) begin
         close_word();
         add_token(kind, 1'b0, '0, col, 12'd1);
      end else begin
         add_char(c, col);
      end
   endtask

   // Work out every token that one accepted byte gives out
   task automatic predict_tokens(input logic [7:0] c);
      logic [COL_W-1:0]  col;
      held_symbol_type   h;
      logic              taken;
      logic [7:0]        second;
      logic [KIND_W-1:0] pair_kind;
      logic [KIND_W-1:0] lone_kind;
      kst_result_type    t;
      if (tokenizer_halted) return;
      col = at_column;
      h = held_symbol;
      taken = 1'b0;
      held_symbol = HELD_NONE;
      step_tokens.delete();
      second = "=";
      pair_kind = KIND_NE;
      lone_kind = KIND_BANG;
      case (h)
         HELD_EQ:  begin pair_kind = KIND_EQ; lone_kind = KIND_ASSIGN; end
         HELD_GT:  begin pair_kind = KIND_GE; lone_kind = KIND_GT; end
         HELD_LT:  begin pair_kind = KIND_LE; lone_kind = KIND_LT; end
         HELD_AMP: begin second = "&"; pair_kind = KIND_AND; end
         HELD_BAR: begin second = "|"; pair_kind = KIND_OR; end
         default: ;
      endcase
      if (h != HELD_NONE) begin
         if (c == second) begin
            close_word();
            add_token(pair_kind, 1'b0, '0, held_column, 12'd2);
            taken = 1'b1;
         end else if (h == HELD_AMP || h == HELD_BAR) begin
            // a lone & or | is an ordinary word byte at its own column
            add_char(second, held_column);
         end else begin
            add_token(lone_kind, 1'b0, '0, held_column, 12'd1);
         end
      end
      if (!taken && !tokenizer_halted) take_char(c, col);

      if (c == CH_NL) begin
         if (at_line != LINE_LAST) at_line = at_line + 1'b1;
         at_column = '0;
      end else if (at_column != COL_LAST) begin
         at_column = at_column + 1'b1;
      end

      foreach (step_tokens[i]) begin
         t = step_tokens[i];
         t.last_of_run = (i == step_tokens.size() - 1);
         expected_tokens = {expected_tokens, t};
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [VALUE_W-1:0] want,
                                input logic [VALUE_W-1:0] seen);
      if (want !== seen) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
   endtask

   task automatic check_token();
      kst_result_type want;
      if (expected_tokens.size() == 0) begin
         mismatch_count++;
         $display("%0t ns: token transfer with none expected, actual kind %0d line %0d col %0d",
                  $time, rsp_chan.token_kind, rsp_chan.line_number, rsp_chan.start_column);
      end else begin
         want = expected_tokens.pop_front();
         compare_field("token_kind", VALUE_W'(want.token_kind), VALUE_W'(rsp_chan.token_kind));
         compare_field("status", VALUE_W'(want.status), VALUE_W'(rsp_chan.status));
         compare_field("number_value", want.number_value, rsp_chan.number_value);
         compare_field("line_number", VALUE_W'(want.line_number),
                       VALUE_W'(rsp_chan.line_number));
         compare_field("start_column", VALUE_W'(want.start_column),
                       VALUE_W'(rsp_chan.start_column));
         compare_field("token_length", VALUE_W'(want.token_length),
                       VALUE_W'(rsp_chan.token_length));
         compare_field("last_of_run", VALUE_W'(want.last_of_run),
                       VALUE_W'(rsp_chan.last_of_run));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Driver: offer the next byte from the backlog, idling at random
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         // predict on the transfer itself, so stalls never skew the order
         if (req_chan.valid && req_chan.ready) begin
            predict_tokens(req_chan.char_code);
            chars_taken <= chars_taken + 1;
         end
         // hold the current byte until it transfers, then pick the next one
         if (!req_chan.valid || req_chan.ready) begin
            if (char_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_chan.valid     <= 1'b1;
               req_chan.char_code <= char_backlog.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: check every result transfer, stall at random, and once hold off
   // long enough that the result queue fills and the input side backs up
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_token();
         if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && chars_taken >= HOLD_AFTER) begin
            hold_done      <= 1'b1;
            hold_left      <= HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      char_backlog = {char_backlog, b};
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) char_backlog = {char_backlog, s[i]};
   endtask

   function automatic logic [7:0] any_letter();
      if ($urandom_range(3) == 0) return 8'("A" + $urandom_range(25));
      return 8'("a" + $urandom_range(25));
   endfunction

   function automatic logic [7:0] any_digit();
      return 8'("0" + $urandom_range(9));
   endfunction

   initial begin
      int    pick;
      int    roll;
      int    len;
      int    random_start;
      int    drain_wait;
      string word;
      logic  joinable;

      // drive every input to a known level before the first edge
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.char_code = '0;
      rsp_chan.ready     = 1'b0;

      // Directed: a pair right after a word, the largest good number, a pair
      // that closes a number, a lone bar inside a word, the byte extremes as
      // word bytes, and comparison starters that fall back to single symbols.
      push_text("a!=2147483647&&b|c\n");
      push_byte(8'h00);
      push_byte(8'hFF);
      push_text("<=>!\n= ==\n");

      // Random: mostly well-formed tokens with random content, some noise.
      // Every digit-led word ends at a delimiter so no number can overflow here.
      random_start = char_backlog.size();
      while (char_backlog.size() - random_start < RANDOM_CHARS) begin
         pick = $urandom_range(99);
         joinable = 1'b0;
         if (pick < 25) begin
            // keyword, now and then one byte too long or too short
            word = keyword_words[$urandom_range(KW_COUNT - 1)];
            roll = $urandom_range(99);
            if (roll >= 85) word = word.substr(0, word.len() - 2);
            push_text(word);
            if (roll >= 70 && roll < 85) push_byte(any_letter());
            joinable = 1'b1;
         end else if (pick < 45) begin
            // identifier, sometimes past the keyword window, with stray & and |
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
            push_byte(($urandom_range(4) == 0) ? "_" : any_letter());
            for (int i = 1; i < len; i++) begin
               roll = $urandom_range(9);
               push_byte(roll < 2 ? any_digit() : roll == 2 ? "&" : roll == 3 ? "|" :
                         any_letter());
            end
            joinable = 1'b1;
         end else if (pick < 60) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
               push_text("2147483647");
            end else begin
               // ten digits always stay in range with a leading one
               len = (roll < 15) ? 10 : $urandom_range(1, 9);
               if (roll >= 15 && roll < 20) push_text("000000000000");
               for (int i = 0; i < len; i++)
                  push_byte((i == 0 && len == 10) ? "1" : any_digit());
               // trailing letters end the value but not the word
               if (roll >= 90) begin
                  push_byte(any_letter());
                  push_byte(any_digit());
               end
            end
         end else if (pick < 85) begin
            push_text(symbol_words[$urandom_range(22)]);
            joinable = 1'b1;
         end else begin
            // noise: any byte at all
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) push_byte(8'($urandom_range(255)));
         end
         roll = $urandom_range(99);
         if (!(joinable && roll >= 85))
            push_byte(roll < 60 ? CH_SPACE : roll < 70 ? CH_TAB : CH_NL);
      end

      // A short statement with a comparison, an assignment and braces
      push_text("while(k>=0){k=k-1;}\n");

      // Overflow last of all: one error token, then silence for good
      push_text("99999999999+x");
      push_text(" a;b\n(");

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // wait for the backlog to drain and the last byte to transfer
      while (char_backlog.size() != 0 || req_chan.valid) @(posedge clock);

      drain_wait = 0;
      while (expected_tokens.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      // let any stray result surface
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_tokens.size() != 0)
         $display("%0t ns: %0d expected tokens never arrived, next kind %0d line %0d",
                  $time, expected_tokens.size(), expected_tokens[0].token_kind,
                  expected_tokens[0].line_number);

      if (mismatch_count == 0 && expected_tokens.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
